// ----- design/overlap_clip_to_clear_range_macros.svh -----
`ifndef OVERLAP_CLIP_TO_CLEAR_RANGE_MACROS_SVH
`define OVERLAP_CLIP_TO_CLEAR_RANGE_MACROS_SVH

// Both macros expect clk in the scope where they are used; OCR_ASSERT also expects rst_n.
`define OCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked in reset as well.
`define OCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/ocr_pkg.sv -----
`timescale 1ns / 1ps
package ocr_pkg;

    localparam int COORD_BITS = 24;
    localparam int ID_BITS    = 32;
    localparam int SNAP_BITS  = 8;
    localparam int SW         = COORD_BITS + 2;
    localparam int LATENCY    = 4 + COORD_BITS + 5;
    localparam logic [SNAP_BITS-1:0] SNAP_RESET = 8'd15;

    typedef logic [COORD_BITS-1:0]         coord_t;
    typedef logic signed [SW-1:0]          scoord_t;
    typedef logic [2*COORD_BITS-1:0]       prod_t;

    typedef struct packed {
        logic [ID_BITS-1:0] query_id;
        logic               query_reverse;
        coord_t             query_length;
        coord_t             query_ovl_start;
        coord_t             query_ovl_stop;
        coord_t             target_ovl_start;
        coord_t             target_ovl_stop;
        logic               query_clear_empty;
        coord_t             query_clear_left;
        coord_t             query_clear_right;
        coord_t             target_clear_left;
        coord_t             target_clear_right;
    } ovl_in_t;

    typedef struct packed {
        logic               keep;
        logic [ID_BITS-1:0] out_query_id;
        coord_t             adj_target_start;
        coord_t             adj_target_stop;
        coord_t             adj_query_start;
        coord_t             adj_query_stop;
    } ovl_out_t;

endpackage

// ----- design/ocr_div.sv -----
`timescale 1ns / 1ps
module ocr_div (
    input  logic           clk,
    input  ocr_pkg::prod_t  num,
    input  ocr_pkg::coord_t den,
    output ocr_pkg::coord_t quo,
    output ocr_pkg::coord_t rem
);
    import ocr_pkg::*;

    // Restoring division, one quotient bit per stage. The upper half of num
    // must be below den, which holds for every kept record.
    coord_t rem_reg [COORD_BITS];
    coord_t lo_reg  [COORD_BITS];
    coord_t quo_reg [COORD_BITS];
    coord_t den_reg [COORD_BITS];

    coord_t rem_d [COORD_BITS];
    coord_t lo_d  [COORD_BITS];
    coord_t quo_d [COORD_BITS];
    coord_t den_d [COORD_BITS];

    genvar k;
    generate
        for (k = 0; k < COORD_BITS; k++)
        begin : g_step
            logic [COORD_BITS:0] trial;
            logic [COORD_BITS:0] diff;
            logic                ge;
            coord_t              rem_next;

            if (k == 0)
            begin : g_first
                assign rem_d[k] = num[2*COORD_BITS-1:COORD_BITS];
                assign lo_d[k]  = num[COORD_BITS-1:0];
                assign quo_d[k] = '0;
                assign den_d[k] = den;
            end
            else
            begin : g_next
                assign rem_d[k] = rem_reg[k-1];
                assign lo_d[k]  = lo_reg[k-1];
                assign quo_d[k] = quo_reg[k-1];
                assign den_d[k] = den_reg[k-1];
            end

            assign trial    = {rem_d[k], lo_d[k][COORD_BITS-1]};
            assign diff     = trial - {1'b0, den_d[k]};
            assign ge       = trial >= {1'b0, den_d[k]};
            assign rem_next = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                lo_reg[k]  <= {lo_d[k][COORD_BITS-2:0], 1'b0};
                quo_reg[k] <= {quo_d[k][COORD_BITS-2:0], ge};
                den_reg[k] <= den_d[k];
            end
        end
    endgenerate

    assign quo = quo_reg[COORD_BITS-1];
    assign rem = rem_reg[COORD_BITS-1];

endmodule

// ----- design/overlap_clip_to_clear_range.sv -----
`timescale 1ns / 1ps
// Channel   | Signals                     | Beat taken when
// ----------+-----------------------------+---------------------------
// request   | start, busy, req            | start high, busy low
// result    | done, rsp                   | done high (one cycle)
// config    | cfg_we, cfg_wdata           | cfg_we high
//
// One record enters every cycle; busy is always low.
// Each result passes through stages 1 to 4, the two 24-stage restoring dividers,
// stages 5 to 8 and the output register after its request beat.
// Reset clears the valid bits and sets the snap limit to 15.
// Results cannot be held off, so nothing in the pipeline ever stalls.
module overlap_clip_to_clear_range (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ocr_pkg::ovl_in_t                req,
    output logic                            done,
    output ocr_pkg::ovl_out_t               rsp,
    input  logic                            cfg_we,
    input  logic [ocr_pkg::SNAP_BITS-1:0]   cfg_wdata
);
    import ocr_pkg::*;

    typedef struct packed {
        logic               keep;
        logic [ID_BITS-1:0] id;
        logic               rev;
        scoord_t            qsize;
        scoord_t            qb;
        scoord_t            qe;
        scoord_t            cb;
        scoord_t            ce;
        scoord_t            tb;
        scoord_t            te;
        scoord_t            tcb;
        scoord_t            tce;
        coord_t             qlen;
        coord_t             tlen;
        coord_t             nqb;
        coord_t             ntb;
        coord_t             nqe;
        coord_t             nte;
        prod_t              pqs;
        prod_t              pts;
        prod_t              pqe;
        prod_t              pte;
        logic               sel_s;
        logic               sel_e;
        coord_t             hang_s;
        coord_t             hang_e;
        coord_t             den_s;
        coord_t             den_e;
        prod_t              num_s;
        prod_t              num_e;
        coord_t             qa_s;
        coord_t             ta_s;
        coord_t             qa_e;
        coord_t             ta_e;
        scoord_t            dqb;
        scoord_t            rtb;
        scoord_t            dqe;
        scoord_t            rte;
    } pipe_t;

    logic [SNAP_BITS-1:0] snap_reg;
    logic [3:0]           vfront_reg;
    logic                 vline_reg [COORD_BITS];
    logic [3:0]           vback_reg;
    logic                 done_reg;

    pipe_t    s1_reg, s2_reg, s3_reg, s4_reg;
    pipe_t    line_reg [COORD_BITS];
    pipe_t    s5_reg, s6_reg, s7_reg, s8_reg;
    ovl_out_t rsp_reg;

    pipe_t    s1_next, s2_next, s3_next, s4_next;
    pipe_t    s5_next, s6_next, s7_next, s8_next;
    ovl_out_t rsp_next;

    coord_t   quo_s, rem_s, quo_e, rem_e;
    logic     accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_reg <= SNAP_RESET;
        end
        else if (cfg_we)
        begin
            snap_reg <= cfg_wdata;
        end
    end

    // Stage 1: strand-local frame, coverage checks, overlap lengths.
    always_comb
    begin
        scoord_t qos, qoe, qcl, qcr;
        s1_next       = '0;
        qos           = scoord_t'({2'b0, req.query_ovl_start});
        qoe           = scoord_t'({2'b0, req.query_ovl_stop});
        qcl           = scoord_t'({2'b0, req.query_clear_left});
        qcr           = scoord_t'({2'b0, req.query_clear_right});
        s1_next.id    = req.query_id;
        s1_next.rev   = req.query_reverse;
        s1_next.qsize = scoord_t'({2'b0, req.query_length});
        s1_next.tb    = scoord_t'({2'b0, req.target_ovl_start});
        s1_next.te    = scoord_t'({2'b0, req.target_ovl_stop});
        s1_next.tcb   = scoord_t'({2'b0, req.target_clear_left});
        s1_next.tce   = scoord_t'({2'b0, req.target_clear_right});
        if (req.query_reverse)
        begin
            s1_next.qb = s1_next.qsize - qoe;
            s1_next.qe = s1_next.qsize - qos;
            s1_next.cb = s1_next.qsize - qcr;
            s1_next.ce = s1_next.qsize - qcl;
        end
        else
        begin
            s1_next.qb = qos;
            s1_next.qe = qoe;
            s1_next.cb = qcl;
            s1_next.ce = qcr;
        end
        s1_next.keep = !req.query_clear_empty
                    && (s1_next.qb >= 0) && (s1_next.qe >= 0)
                    && (s1_next.ce > s1_next.qb) && (s1_next.qe > s1_next.cb)
                    && (s1_next.tce > s1_next.tb) && (s1_next.te > s1_next.tcb)
                    && (s1_next.qe > s1_next.qb) && (s1_next.te > s1_next.tb);
        s1_next.qlen = coord_t'(s1_next.qe - s1_next.qb);
        s1_next.tlen = coord_t'(s1_next.te - s1_next.tb);
    end

    // Stage 2: hangs past the clear edges.
    always_comb
    begin
        scoord_t nqb, ntb, nqe, nte;
        s2_next = s1_reg;
        nqb = (s1_reg.cb > s1_reg.qb) ? s1_reg.cb - s1_reg.qb : '0;
        ntb = (s1_reg.tcb > s1_reg.tb) ? s1_reg.tcb - s1_reg.tb : '0;
        nqe = (s1_reg.ce < s1_reg.qe) ? s1_reg.qe - s1_reg.ce : '0;
        nte = (s1_reg.tce < s1_reg.te) ? s1_reg.te - s1_reg.tce : '0;
        s2_next.nqb  = coord_t'(nqb);
        s2_next.ntb  = coord_t'(ntb);
        s2_next.nqe  = coord_t'(nqe);
        s2_next.nte  = coord_t'(nte);
        s2_next.keep = s1_reg.keep
                    && (nqb < scoord_t'({2'b0, s1_reg.qlen}))
                    && (nqe < scoord_t'({2'b0, s1_reg.qlen}))
                    && (ntb < scoord_t'({2'b0, s1_reg.tlen}))
                    && (nte < scoord_t'({2'b0, s1_reg.tlen}));
    end

    // Stage 3: cross products of hangs and lengths.
    always_comb
    begin
        s3_next     = s2_reg;
        s3_next.pqs = s2_reg.nqb * s2_reg.tlen;
        s3_next.pts = s2_reg.ntb * s2_reg.qlen;
        s3_next.pqe = s2_reg.nqe * s2_reg.tlen;
        s3_next.pte = s2_reg.nte * s2_reg.qlen;
    end

    // Stage 4: the read with the larger fraction sets each trim.
    always_comb
    begin
        s4_next        = s3_reg;
        s4_next.sel_s  = s3_reg.pqs >= s3_reg.pts;
        s4_next.sel_e  = s3_reg.pqe >= s3_reg.pte;
        s4_next.hang_s = s4_next.sel_s ? s3_reg.nqb : s3_reg.ntb;
        s4_next.num_s  = s4_next.sel_s ? s3_reg.pqs : s3_reg.pts;
        s4_next.den_s  = s4_next.sel_s ? s3_reg.qlen : s3_reg.tlen;
        s4_next.hang_e = s4_next.sel_e ? s3_reg.nqe : s3_reg.nte;
        s4_next.num_e  = s4_next.sel_e ? s3_reg.pqe : s3_reg.pte;
        s4_next.den_e  = s4_next.sel_e ? s3_reg.qlen : s3_reg.tlen;
    end

    ocr_div u_div_s (
        .clk (clk),
        .num (s4_reg.num_s),
        .den (s4_reg.den_s),
        .quo (quo_s),
        .rem (rem_s)
    );

    ocr_div u_div_e (
        .clk (clk),
        .num (s4_reg.num_e),
        .den (s4_reg.den_e),
        .quo (quo_e),
        .rem (rem_e)
    );

    // Stage 5: round half up and pair each trim with its read.
    always_comb
    begin
        coord_t qd_s, qd_e;
        s5_next = line_reg[COORD_BITS-1];
        qd_s = quo_s + coord_t'({rem_s, 1'b0} >= {1'b0, s5_next.den_s});
        qd_e = quo_e + coord_t'({rem_e, 1'b0} >= {1'b0, s5_next.den_e});
        s5_next.qa_s = s5_next.sel_s ? s5_next.hang_s : qd_s;
        s5_next.ta_s = s5_next.sel_s ? qd_s : s5_next.hang_s;
        s5_next.qa_e = s5_next.sel_e ? s5_next.hang_e : qd_e;
        s5_next.ta_e = s5_next.sel_e ? qd_e : s5_next.hang_e;
    end

    // Stage 6: apply the trims.
    always_comb
    begin
        s6_next    = s5_reg;
        s6_next.qb = s5_reg.qb + scoord_t'({2'b0, s5_reg.qa_s});
        s6_next.tb = s5_reg.tb + scoord_t'({2'b0, s5_reg.ta_s});
        s6_next.qe = s5_reg.qe - scoord_t'({2'b0, s5_reg.qa_e});
        s6_next.te = s5_reg.te - scoord_t'({2'b0, s5_reg.ta_e});
    end

    // Stage 7: remaining hangs and the target's room at each end.
    always_comb
    begin
        s7_next     = s6_reg;
        s7_next.dqb = s6_reg.qb - s6_reg.cb;
        s7_next.rtb = s6_reg.tb - s6_reg.tcb;
        s7_next.dqe = s6_reg.ce - s6_reg.qe;
        s7_next.rte = s6_reg.tce - s6_reg.te;
    end

    // Stage 8: snap short hangs back toward the clear edges.
    always_comb
    begin
        scoord_t lim, adj_b, adj_e;
        s8_next = s7_reg;
        lim   = scoord_t'({{(SW-SNAP_BITS){1'b0}}, snap_reg});
        adj_b = (s7_reg.dqb > s7_reg.rtb) ? s7_reg.rtb : s7_reg.dqb;
        adj_e = (s7_reg.dqe > s7_reg.rte) ? s7_reg.rte : s7_reg.dqe;
        if (s7_reg.dqb < lim)
        begin
            s8_next.qb = s7_reg.qb - adj_b;
            s8_next.tb = s7_reg.tb - adj_b;
        end
        if (s7_reg.dqe < lim)
        begin
            s8_next.qe = s7_reg.qe + adj_e;
            s8_next.te = s7_reg.te + adj_e;
        end
    end

    // Output stage: back to the input's strand frame.
    always_comb
    begin
        scoord_t rq_b, rq_e;
        rsp_next = '0;
        rq_b = s8_reg.rev ? s8_reg.qsize - s8_reg.qe : s8_reg.qb;
        rq_e = s8_reg.rev ? s8_reg.qsize - s8_reg.qb : s8_reg.qe;
        rsp_next.keep         = s8_reg.keep;
        rsp_next.out_query_id = s8_reg.id;
        if (s8_reg.keep)
        begin
            rsp_next.adj_target_start = coord_t'(s8_reg.tb);
            rsp_next.adj_target_stop  = coord_t'(s8_reg.te);
            rsp_next.adj_query_start  = coord_t'(rq_b);
            rsp_next.adj_query_stop   = coord_t'(rq_e);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        s3_reg  <= s3_next;
        s4_reg  <= s4_next;
        s5_reg  <= s5_next;
        s6_reg  <= s6_next;
        s7_reg  <= s7_next;
        s8_reg  <= s8_next;
        rsp_reg <= rsp_next;
    end

    genvar k;
    generate
        for (k = 0; k < COORD_BITS; k++)
        begin : g_line
            always_ff @(posedge clk)
            begin
                line_reg[k] <= (k == 0) ? s4_reg : line_reg[(k == 0) ? 0 : k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vline_reg[k] <= 1'b0;
                end
                else
                begin
                    vline_reg[k] <= (k == 0) ? vfront_reg[3]
                                             : vline_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vfront_reg <= '0;
            vback_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            vfront_reg <= {vfront_reg[2:0], accept};
            vback_reg  <= {vback_reg[2:0], vline_reg[COORD_BITS-1]};
            done_reg   <= vback_reg[3];
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- design/ocr_checker.sv -----
`timescale 1ns / 1ps
`include "overlap_clip_to_clear_range_macros.svh"
module ocr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input ocr_pkg::ovl_in_t  req,
    input logic              done,
    input ocr_pkg::ovl_out_t rsp
);
    import ocr_pkg::*;

    `OCR_ASSERT_ALWAYS(a_never_busy, !busy, "busy went high")

    // A dropped record carries no coordinates.
    `OCR_ASSERT(a_drop_zero, done && !rsp.keep |-> rsp.adj_target_start == '0 && rsp.adj_target_stop == '0 && rsp.adj_query_start == '0 && rsp.adj_query_stop == '0, "dropped record has coordinates")

    // Every result beat traces back to a request beat a fixed depth earlier.
    `OCR_ASSERT(a_latency_id, done |-> $past(start, LATENCY) && rsp.out_query_id == $past(req.query_id, LATENCY), "result without matching request")

endmodule

bind overlap_clip_to_clear_range ocr_checker u_ocr_checker (.*);

// ----- bench/overlap_clip_to_clear_range_test.sv -----
`timescale 1ns / 1ps
module overlap_clip_to_clear_range_test;
    import ocr_pkg::*;

    localparam int DRAIN_CYCLES = LATENCY + 20;
    localparam int CYCLE_LIMIT  = 400000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    ovl_in_t    req;
    logic       done;
    ovl_out_t   rsp;
    logic       cfg_we;
    logic [SNAP_BITS-1:0] cfg_wdata;

    // Predictor state: the snap limit the block holds.
    logic [SNAP_BITS-1:0] snap_limit;
    int unsigned cycle_count;
    int unsigned beats_sent;
    int unsigned kept_count;

    overlap_clip_to_clear_range dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // round(a * b / d), half up.
    function automatic longint scaled_trim(longint a, longint b, longint d);
        longint unsigned p;
        longint unsigned q;
        longint unsigned r;
        p = longint'(a) * longint'(b);
        q = p / d;
        r = p % d;
        if (r >= longint'(d) - r)
            q++;
        return q;
    endfunction

    function automatic ovl_out_t clip_overlap(ovl_in_t x, logic [SNAP_BITS-1:0] lim_in);
        ovl_out_t o;
        longint qsize, qb, qe, cb, ce, tb, te, tcb, tce, qlen, tlen;
        longint nqb, ntb, nqe, nte, qa, ta, lim, room, adj;
        o = '0;
        o.out_query_id = x.query_id;
        lim = longint'(lim_in);
        qsize = longint'(x.query_length);
        tb = longint'(x.target_ovl_start);
        te = longint'(x.target_ovl_stop);
        tcb = longint'(x.target_clear_left);
        tce = longint'(x.target_clear_right);
        if (x.query_clear_empty)
            return o;
        if (x.query_reverse)
        begin
            qb = qsize - x.query_ovl_stop;
            qe = qsize - x.query_ovl_start;
            cb = qsize - x.query_clear_right;
            ce = qsize - x.query_clear_left;
        end
        else
        begin
            qb = longint'(x.query_ovl_start);
            qe = longint'(x.query_ovl_stop);
            cb = longint'(x.query_clear_left);
            ce = longint'(x.query_clear_right);
        end
        if (qb < 0 || qe < 0)
            return o;
        if (ce <= qb || qe <= cb || tce <= tb || te <= tcb)
            return o;
        qlen = qe - qb;
        tlen = te - tb;
        if (qlen <= 0 || tlen <= 0)
            return o;
        nqb = (cb > qb) ? cb - qb : 0;
        ntb = (tcb > tb) ? tcb - tb : 0;
        nqe = (ce < qe) ? qe - ce : 0;
        nte = (tce < te) ? te - tce : 0;
        if (nqb >= qlen || nqe >= qlen || ntb >= tlen || nte >= tlen)
            return o;
        if (nqb * tlen >= ntb * qlen)
        begin
            qa = nqb;
            ta = scaled_trim(nqb, tlen, qlen);
        end
        else
        begin
            ta = ntb;
            qa = scaled_trim(ntb, qlen, tlen);
        end
        qb += qa;
        tb += ta;
        if (nqe * tlen >= nte * qlen)
        begin
            qa = nqe;
            ta = scaled_trim(nqe, tlen, qlen);
        end
        else
        begin
            ta = nte;
            qa = scaled_trim(nte, qlen, tlen);
        end
        qe -= qa;
        te -= ta;
        if (qb - cb < lim)
        begin
            room = tb - tcb;
            adj = qb - cb;
            if (adj > room)
                adj = room;
            tb -= adj;
            qb -= adj;
        end
        if (ce - qe < lim)
        begin
            room = tce - te;
            adj = ce - qe;
            if (adj > room)
                adj = room;
            te += adj;
            qe += adj;
        end
        o.keep = 1'b1;
        o.adj_target_start = tb[COORD_BITS-1:0];
        o.adj_target_stop = te[COORD_BITS-1:0];
        if (x.query_reverse)
        begin
            qa = qsize - qe;
            ta = qsize - qb;
        end
        else
        begin
            qa = qb;
            ta = qe;
        end
        o.adj_query_start = qa[COORD_BITS-1:0];
        o.adj_query_stop = ta[COORD_BITS-1:0];
        return o;
    endfunction

    class clip_scoreboard;
        ovl_out_t pending[$];
        int unsigned errors;

        function void note_request(ovl_in_t x, logic [SNAP_BITS-1:0] lim);
            pending.push_back(clip_overlap(x, lim));
        endfunction

        function void check_result(ovl_out_t got);
            ovl_out_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want.keep !== got.keep || want.out_query_id !== got.out_query_id
                || want.adj_target_start !== got.adj_target_start
                || want.adj_target_stop !== got.adj_target_stop
                || want.adj_query_start !== got.adj_query_start
                || want.adj_query_stop !== got.adj_query_stop)
            begin
                $display("%0t: mismatch expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    clip_scoreboard board;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && start && !busy)
        begin
            board.note_request(req, snap_limit);
            beats_sent <= beats_sent + 1;
        end
        if (rst_n && done)
        begin
            board.check_result(rsp);
            if (rsp.keep)
                kept_count <= kept_count + 1;
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("overlap_clip_to_clear_range_test: errors");
            $finish;
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 3))
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 40));
            2: return {COORD_BITS{1'b1}} - coord_t'($urandom_range(0, 40));
            default: return coord_t'($urandom_range(0, 5000));
        endcase
    endfunction

    // Mostly well-formed records: overlaps that cross the clear ranges.
    function automatic ovl_in_t shaped_record();
        ovl_in_t x;
        int unsigned base, span;
        x.query_id = $urandom;
        x.query_reverse = 1'($urandom_range(0, 1));
        x.query_clear_empty = ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 9) == 0)
        begin
            x.query_length = rand_coord();
            x.query_ovl_start = rand_coord();
            x.query_ovl_stop = rand_coord();
            x.target_ovl_start = rand_coord();
            x.target_ovl_stop = rand_coord();
            x.query_clear_left = rand_coord();
            x.query_clear_right = rand_coord();
            x.target_clear_left = rand_coord();
            x.target_clear_right = rand_coord();
            return x;
        end
        span = ($urandom_range(0, 7) == 0) ? 24'hFFF000 : 2000;
        x.query_length = coord_t'($urandom_range(span / 2, span));
        x.query_clear_left = coord_t'($urandom_range(0, x.query_length / 4));
        x.query_clear_right = coord_t'(x.query_length
            - $urandom_range(0, x.query_length / 4));
        x.query_ovl_start = coord_t'($urandom_range(0, x.query_length / 3));
        x.query_ovl_stop = coord_t'($urandom_range(x.query_length * 2 / 3,
            x.query_length));
        base = $urandom_range(0, span / 2);
        x.target_ovl_start = coord_t'(base);
        x.target_ovl_stop = coord_t'(base + (x.query_ovl_stop - x.query_ovl_start)
            + $urandom_range(0, 60) - 30);
        x.target_clear_left = coord_t'(base + $urandom_range(0, 80) - 40);
        x.target_clear_right = coord_t'(x.target_ovl_stop + $urandom_range(0, 80) - 40);
        return x;
    endfunction

    task automatic send_record(ovl_in_t x);
        req <= x;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause_sender();
        start <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(negedge clk);
    endtask

    // The caller has already dropped start.
    task automatic write_snap_limit(logic [SNAP_BITS-1:0] value);
        while (board.pending.size() != 0)
            @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        snap_limit <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned burst;
        burst = 0;
        repeat (count)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) != 0)
                    pause_sender();
            end
            send_record(shaped_record());
            burst--;
        end
        start <= 1'b0;
    endtask

    initial
    begin
        ovl_in_t x;
        int unsigned drain;
        board = new();
        cycle_count = 0;
        beats_sent = 0;
        kept_count = 0;
        snap_limit = SNAP_RESET;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed records at the reset limit.
        x = '0;
        x.query_id = 32'hFFFFFFFF;
        x.query_clear_empty = 1'b1;
        send_record(x);
        x = '0;
        x.query_id = 32'h1;
        x.query_length = 24'd1000;
        x.query_ovl_start = 24'd100;
        x.query_ovl_stop = 24'd900;
        x.target_ovl_start = 24'd50;
        x.target_ovl_stop = 24'd850;
        x.query_clear_left = 24'd120;
        x.query_clear_right = 24'd880;
        x.target_clear_left = 24'd40;
        x.target_clear_right = 24'd840;
        send_record(x);
        x.query_reverse = 1'b1;
        send_record(x);
        x.query_ovl_stop = 24'd1200;
        send_record(x);
        x.query_ovl_stop = 24'd900;
        x.query_reverse = 1'b0;
        x.query_clear_right = 24'd90;
        x.query_clear_left = 24'd0;
        send_record(x);
        x.query_clear_right = 24'd880;
        x.target_clear_left = 24'd900;
        x.target_clear_right = 24'd1000;
        send_record(x);
        x.target_clear_left = 24'd40;
        x.target_clear_right = 24'd840;
        x.query_ovl_start = 24'd900;
        send_record(x);
        x.query_ovl_start = 24'd100;
        x.target_ovl_stop = 24'd50;
        send_record(x);
        x.target_ovl_stop = 24'd850;
        x.target_clear_left = 24'd849;
        x.target_clear_right = 24'd2000;
        send_record(x);
        x = '1;
        send_record(x);
        x.query_clear_empty = 1'b0;
        send_record(x);
        x.query_reverse = 1'b0;
        x.query_ovl_start = 24'd0;
        x.target_ovl_start = 24'd0;
        x.query_clear_left = 24'd0;
        x.target_clear_left = 24'd0;
        send_record(x);
        start <= 1'b0;

        write_snap_limit(8'd0);
        random_phase(200);
        write_snap_limit(8'd255);
        random_phase(200);
        write_snap_limit(8'($urandom_range(1, 254)));
        random_phase(200);
        write_snap_limit(SNAP_RESET);
        random_phase(240);

        while (board.pending.size() != 0)
            @(negedge clk);
        drain = 0;
        while (drain < DRAIN_CYCLES)
        begin
            @(negedge clk);
            drain++;
        end
        $display("Sent %0d records over four snap limits (0, 255, random, 15);", beats_sent);
        $display("%0d results kept, the rest dropped.", kept_count);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("overlap_clip_to_clear_range_test: clean");
        else
            $display("overlap_clip_to_clear_range_test: errors");
        $finish;
    end
endmodule
